@@ design/chm_pkg.sv @@
// shared types and constants of the chained hash map engine
package chm_pkg;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c13;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NO_ROOM = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR_CUR,
        OP_CLR_NEW,
        OP_RD_OLD_HEAD,
        OP_CUR_HEAD,
        OP_SCAN_INC,
        OP_SWAP,
        OP_RD_ENT,
        OP_HASH_ENT,
        OP_RD_NEW_HEAD,
        OP_PUSH,
        OP_HASH_REQ,
        OP_RD_HEAD,
        OP_INSERT,
        OP_STEP,
        OP_UNLINK,
        OP_OUT
    } chm_op_t;

    typedef struct packed {
        chm_op_t    op;
        logic [1:0] res_status;
        logic       res_found;
    } chm_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       kb_bad;
        logic       handle_zero;
        logic       full;
        logic       absent;
        logic       need_grow;
        logic       hash_done;
        logic       cur_nil;
        logic       match;
        logic       clr_cur_last;
        logic       clr_new_last;
        logic       scan_last;
        logic       out_busy;
    } chm_stat_t;

endpackage

@@ design/chm_hash.sv @@
// multi-cycle fibonacci hash: high 32 bits of the low 64 bits of folded key times golden constant
module chm_hash
    import chm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [31:0] hash_hi
);

    typedef enum logic [1:0] {H_IDLE, H_LOW, H_CROSS_A, H_CROSS_B} phase_t;

    phase_t      phase_reg;
    logic [63:0] a_reg;
    logic [63:0] p_reg;
    logic [31:0] s_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // one 32x32 multiplier shared over three partial products
    always_comb
    begin
        mul_x = a_reg[31:0];
        mul_y = GOLDEN[31:0];
        unique case (phase_reg)
            H_CROSS_A: mul_x = a_reg[63:32];
            H_CROSS_B: mul_y = GOLDEN[63:32];
            default: ;
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign done    = (phase_reg == H_IDLE);
    assign hash_hi = p_reg[63:32] + s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= H_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                H_IDLE:    if (start) phase_reg <= H_LOW;
                H_LOW:     phase_reg <= H_CROSS_A;
                H_CROSS_A: phase_reg <= H_CROSS_B;
                H_CROSS_B: phase_reg <= H_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        // fold the high half in before multiplying
        if (start && phase_reg == H_IDLE) a_reg <= operand ^ {32'd0, operand[63:32]};
        if (phase_reg == H_LOW) p_reg <= mul_p;
        if (phase_reg == H_CROSS_A) s_reg <= mul_p[31:0];
        if (phase_reg == H_CROSS_B) s_reg <= s_reg + mul_p[31:0];
    end

endmodule

@@ design/chm_datapath.sv @@
// datapath: bucket heads, entry stores, free stack, counters and result register
module chm_datapath
    import chm_pkg::*;
#(
    parameter int MAX_ENTRIES         = 1024,
    parameter int INITIAL_BUCKET_BITS = 4,
    parameter int KEY_BITS            = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  chm_cmd_t    cmd,
    output chm_stat_t   stat,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_key_bytes,
    input  logic [1:0]  in_req_type,
    input  logic [63:0] in_key,
    input  logic [63:0] in_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic        out_found,
    output logic [63:0] out_handle
);

    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int IW      = $clog2(MAX_ENTRIES + 1);
    localparam int BB_GROW = $clog2(MAX_ENTRIES) - 1;
    localparam int BB_MAX  = (INITIAL_BUCKET_BITS > BB_GROW) ? INITIAL_BUCKET_BITS : BB_GROW;
    localparam int BW      = BB_MAX;
    localparam int BBW     = $clog2(BB_MAX + 2);
    localparam int HD      = 2 ** (BW + 1);
    localparam logic [IW-1:0] NIL = IW'(MAX_ENTRIES);

    logic [IW-1:0]       heads_mem [HD];
    logic [KEY_BITS-1:0] keys_mem [MAX_ENTRIES];
    logic [63:0]         handles_mem [MAX_ENTRIES];
    logic [IW-1:0]       links_mem [MAX_ENTRIES];
    logic [AW-1:0]       free_mem [MAX_ENTRIES];

    logic [IW-1:0]       heads_q;
    logic [KEY_BITS-1:0] keys_q;
    logic [63:0]         handles_q;
    logic [IW-1:0]       links_q;
    logic [AW-1:0]       free_q;

    logic [3:0]          kb_reg;
    logic [1:0]          req_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         handle_reg;
    logic [IW-1:0]       count_reg;
    logic [IW-1:0]       hw_reg;
    logic [BBW-1:0]      bb_reg;
    logic                sel_reg;
    logic [BW-1:0]       scan_reg;
    logic [IW-1:0]       cur_reg;
    logic [IW-1:0]       prev_reg;
    logic [IW-1:0]       next_reg;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic                found_reg;
    logic [63:0]         fh_reg;

    logic [63:0]         cm64;
    logic [KEY_BITS-1:0] cm_k;
    logic [BBW-1:0]      bits_new;
    logic                hash_start;
    logic [63:0]         hash_operand;
    logic                hash_done;
    logic [31:0]         hash_hi;
    logic [BW-1:0]       bucket_cur;
    logic [BW-1:0]       bucket_new;
    logic [IW-1:0]       alloc;
    logic [IW-1:0]       cnt_dec;

    logic                h_we;
    logic [BW:0]         h_waddr;
    logic [IW-1:0]       h_wdata;
    logic                h_re;
    logic [BW:0]         h_raddr;
    logic                l_we;
    logic [AW-1:0]       l_waddr;
    logic [IW-1:0]       l_wdata;

    function automatic logic [BW-1:0] bucket_of(logic [31:0] hi, logic [BBW-1:0] bits);
        logic [31:0] h;
        h = hi >> (6'd32 - 6'(bits));
        if (h >= 32'(MAX_ENTRIES)) h = '0;
        return h[BW-1:0];
    endfunction

    always_comb
    begin
        if (kb_reg >= 4'd8) cm64 = '1;
        else cm64 = (64'd1 << {kb_reg[2:0], 3'b000}) - 64'd1;
        cm_k = cm64[KEY_BITS-1:0];
    end

    assign bits_new     = bb_reg + 1'b1;
    assign hash_start   = (cmd.op == OP_HASH_REQ) || (cmd.op == OP_HASH_ENT);
    assign hash_operand = (cmd.op == OP_HASH_ENT) ? 64'(keys_q & cm_k) : 64'(key_reg);
    assign bucket_cur   = bucket_of(hash_hi, bb_reg);
    assign bucket_new   = bucket_of(hash_hi, bits_new);
    // free-stack slots at or above the high-water mark are unwritten; the count names a fresh entry
    assign alloc        = (count_reg < hw_reg) ? IW'(free_q) : count_reg;
    assign cnt_dec      = count_reg - 1'b1;

    chm_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .operand (hash_operand),
        .done    (hash_done),
        .hash_hi (hash_hi)
    );

    always_comb
    begin
        stat.req_type     = req_reg;
        stat.kb_bad       = (kb_reg == 4'd0) || (kb_reg > 4'd8);
        stat.handle_zero  = (handle_reg == 64'd0);
        stat.full         = (count_reg >= NIL);
        stat.absent       = (bb_reg == '0);
        stat.need_grow    = (32'(count_reg) + 32'd1) > (32'd2 << bb_reg);
        stat.hash_done    = hash_done;
        stat.cur_nil      = (cur_reg == NIL);
        stat.match        = ((keys_q & cm_k) == key_reg);
        stat.clr_cur_last = 32'(scan_reg) == ((32'd1 << INITIAL_BUCKET_BITS) - 32'd1);
        stat.clr_new_last = 32'(scan_reg) == ((32'd1 << bits_new) - 32'd1);
        stat.scan_last    = 32'(scan_reg) == ((32'd1 << bb_reg) - 32'd1);
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = {sel_reg, scan_reg};
        h_wdata = NIL;
        h_re    = 1'b0;
        h_raddr = {sel_reg, bucket_cur};
        l_we    = 1'b0;
        l_waddr = cur_reg[AW-1:0];
        l_wdata = heads_q;
        unique case (cmd.op)
            OP_CLR_CUR: h_we = 1'b1;
            OP_CLR_NEW:
            begin
                h_we    = 1'b1;
                h_waddr = {~sel_reg, scan_reg};
            end
            OP_RD_OLD_HEAD:
            begin
                h_re    = 1'b1;
                h_raddr = {sel_reg, scan_reg};
            end
            OP_RD_NEW_HEAD:
            begin
                h_re    = 1'b1;
                h_raddr = {~sel_reg, bucket_new};
            end
            OP_RD_HEAD: h_re = 1'b1;
            OP_PUSH:
            begin
                h_we    = 1'b1;
                h_waddr = {~sel_reg, bucket_new};
                h_wdata = cur_reg;
                l_we    = 1'b1;
            end
            OP_INSERT:
            begin
                h_we    = 1'b1;
                h_waddr = {sel_reg, bucket_cur};
                h_wdata = cur_reg;
                l_we    = 1'b1;
            end
            OP_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    h_we    = 1'b1;
                    h_waddr = {sel_reg, bucket_cur};
                    h_wdata = links_q;
                end
                else
                begin
                    l_we    = 1'b1;
                    l_waddr = prev_reg[AW-1:0];
                    l_wdata = links_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (h_we) heads_mem[h_waddr] <= h_wdata;
        if (h_re) heads_q <= heads_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_INSERT)
        begin
            keys_mem[cur_reg[AW-1:0]]    <= key_reg;
            handles_mem[cur_reg[AW-1:0]] <= handle_reg;
        end
        if (l_we) links_mem[l_waddr] <= l_wdata;
        if (cmd.op == OP_RD_ENT)
        begin
            keys_q    <= keys_mem[cur_reg[AW-1:0]];
            handles_q <= handles_mem[cur_reg[AW-1:0]];
            links_q   <= links_mem[cur_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_UNLINK) free_mem[cnt_dec[AW-1:0]] <= cur_reg[AW-1:0];
        if (cmd.op == OP_HASH_REQ) free_q <= free_mem[count_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_reg        <= 4'd8;
            count_reg     <= '0;
            hw_reg        <= '0;
            bb_reg        <= '0;
            sel_reg       <= 1'b0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid) kb_reg <= cfg_key_bytes;
            unique case (cmd.op)
                OP_CLR_CUR:
                begin
                    bb_reg   <= BBW'(INITIAL_BUCKET_BITS);
                    scan_reg <= stat.clr_cur_last ? '0 : scan_reg + 1'b1;
                end
                OP_CLR_NEW: scan_reg <= stat.clr_new_last ? '0 : scan_reg + 1'b1;
                OP_SCAN_INC: scan_reg <= scan_reg + 1'b1;
                OP_SWAP:
                begin
                    sel_reg  <= ~sel_reg;
                    bb_reg   <= bits_new;
                    scan_reg <= '0;
                end
                OP_INSERT:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == hw_reg) hw_reg <= count_reg + 1'b1;
                end
                OP_UNLINK:
                begin
                    count_reg <= cnt_dec;
                    // last entry gone: table becomes absent
                    if (cnt_dec == '0) bb_reg <= '0;
                end
                default: ;
            endcase
            if (cmd.op == OP_OUT) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg    <= in_req_type;
                key_reg    <= in_key[KEY_BITS-1:0];
                handle_reg <= in_handle;
            end
            OP_CUR_HEAD:
            begin
                cur_reg  <= heads_q;
                prev_reg <= NIL;
            end
            OP_RD_HEAD: cur_reg <= alloc;
            OP_HASH_ENT: next_reg <= links_q;
            OP_PUSH: cur_reg <= next_reg;
            OP_STEP:
            begin
                prev_reg <= cur_reg;
                cur_reg  <= links_q;
            end
            OP_OUT:
            begin
                status_reg <= cmd.res_status;
                found_reg  <= cmd.res_found;
                fh_reg     <= cmd.res_found ? handles_q : 64'd0;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_handle = fh_reg;

endmodule

@@ design/chm_ctrl.sv @@
// controller: sequences requests, table creation, growth rehash and chain walks
module chm_ctrl
    import chm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  chm_stat_t stat,
    output chm_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_CREATE, S_GCHK, S_GCLR, S_GRD, S_GCUR, S_GTEST,
        S_GHASH, S_GWAIT, S_GRDN, S_GPUSH, S_IHASH, S_IWAIT, S_IRDH, S_IWR,
        S_LHASH, S_LWAIT, S_LRDH, S_LCUR, S_LTEST, S_LCMP, S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] res_status_reg;
    logic [1:0] res_status_next;
    logic       res_found_reg;
    logic       res_found_next;
    chm_op_t    op;

    always_comb
    begin
        state_next      = state_reg;
        op              = OP_NOP;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op              = OP_LOAD;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.req_type == REQ_NONE) state_next = S_DONE;
                else if (stat.kb_bad)
                begin
                    res_status_next = ST_INVALID;
                    state_next      = S_DONE;
                end
                else if (stat.req_type == REQ_INSERT)
                begin
                    priority if (stat.handle_zero)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else if (stat.full)
                    begin
                        res_status_next = ST_NO_ROOM;
                        state_next      = S_DONE;
                    end
                    else if (stat.absent) state_next = S_CREATE;
                    else state_next = S_GCHK;
                end
                else if (stat.absent) state_next = S_DONE;
                else state_next = S_LHASH;
            end
            S_CREATE:
            begin
                op = OP_CLR_CUR;
                if (stat.clr_cur_last) state_next = S_GCHK;
            end
            S_GCHK: state_next = stat.need_grow ? S_GCLR : S_IHASH;
            S_GCLR:
            begin
                op = OP_CLR_NEW;
                if (stat.clr_new_last) state_next = S_GRD;
            end
            S_GRD:
            begin
                op         = OP_RD_OLD_HEAD;
                state_next = S_GCUR;
            end
            S_GCUR:
            begin
                op         = OP_CUR_HEAD;
                state_next = S_GTEST;
            end
            S_GTEST:
            begin
                if (stat.cur_nil)
                begin
                    if (stat.scan_last)
                    begin
                        op         = OP_SWAP;
                        state_next = S_IHASH;
                    end
                    else
                    begin
                        op         = OP_SCAN_INC;
                        state_next = S_GRD;
                    end
                end
                else
                begin
                    op         = OP_RD_ENT;
                    state_next = S_GHASH;
                end
            end
            S_GHASH:
            begin
                op         = OP_HASH_ENT;
                state_next = S_GWAIT;
            end
            S_GWAIT: if (stat.hash_done) state_next = S_GRDN;
            S_GRDN:
            begin
                op         = OP_RD_NEW_HEAD;
                state_next = S_GPUSH;
            end
            S_GPUSH:
            begin
                op         = OP_PUSH;
                state_next = S_GTEST;
            end
            S_IHASH:
            begin
                op         = OP_HASH_REQ;
                state_next = S_IWAIT;
            end
            S_IWAIT: if (stat.hash_done) state_next = S_IRDH;
            S_IRDH:
            begin
                op         = OP_RD_HEAD;
                state_next = S_IWR;
            end
            S_IWR:
            begin
                op         = OP_INSERT;
                state_next = S_DONE;
            end
            S_LHASH:
            begin
                op         = OP_HASH_REQ;
                state_next = S_LWAIT;
            end
            S_LWAIT: if (stat.hash_done) state_next = S_LRDH;
            S_LRDH:
            begin
                op         = OP_RD_HEAD;
                state_next = S_LCUR;
            end
            S_LCUR:
            begin
                op         = OP_CUR_HEAD;
                state_next = S_LTEST;
            end
            S_LTEST:
            begin
                if (stat.cur_nil) state_next = S_DONE;
                else
                begin
                    op         = OP_RD_ENT;
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (stat.match)
                begin
                    res_found_next = (stat.req_type == REQ_FIND);
                    if (stat.req_type == REQ_REMOVE) op = OP_UNLINK;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_STEP;
                    state_next = S_LTEST;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cmd      = '{op: op, res_status: res_status_reg, res_found: res_found_reg};

endmodule

@@ design/chained_hash_map_engine.sv @@
// top level of the chained hash map engine
// usage:
// - request channel (in_valid/in_ready) carries req_type, key and object_handle;
//   one word is taken at a time, and every request returns exactly one result word
// - result channel (out_valid/out_ready) carries status, found and found_handle
//   from an output register; the next request is taken while a result waits,
//   and the engine holds before writing a new result until the old one is taken
// - config channel (cfg_valid/cfg_ready) writes key_bytes; always ready, write
//   only while no request is in flight
// - a find or remove hashes the key, reads the bucket head and walks the chain
//   one entry at a time; while the table is absent a find or remove skips the
//   hash and the walk; an insert hashes, reads the head and writes the entry; the
//   next request can be taken in the same cycle as the result shows up; the hash
//   unit's shared 32x32 multiplier (3 passes) and the registered memory reads set the latency
// - the first insert into an empty table clears 2^INITIAL_BUCKET_BITS heads, one a cycle
// - growth clears 2^(bits+1) heads, then walks each old bucket and
//   rehashes each entry into the other head bank
// - reset: table absent, no entries, key_bytes 8; no clearing pass is needed
module chained_hash_map_engine
    import chm_pkg::*;
#(
    parameter int MAX_ENTRIES         = 1024,
    parameter int INITIAL_BUCKET_BITS = 4,
    parameter int KEY_BITS            = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] key,
    input  logic [63:0] object_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [63:0] found_handle,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  key_bytes
);

    chm_cmd_t  cmd;
    chm_stat_t stat;

    assign cfg_ready = 1'b1;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chm_datapath #(
        .MAX_ENTRIES         (MAX_ENTRIES),
        .INITIAL_BUCKET_BITS (INITIAL_BUCKET_BITS),
        .KEY_BITS            (KEY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_key_bytes (key_bytes),
        .in_req_type   (req_type),
        .in_key        (key),
        .in_handle     (object_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_status    (status),
        .out_found     (found),
        .out_handle    (found_handle)
    );

endmodule
